FILE: hw/rtl/pptd_pkg.sv
package pptd_pkg;

  // Default sizes of the task queue and the nesting stack.
  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_NEST_DEPTH  = 16;

  // Running priority when no task is dispatched, after reset.
  localparam logic [3:0] RESET_BASE_PRIORITY = 4'd9;

  // Item function codes.
  localparam logic FUNC_ADD    = 1'b0;
  localparam logic FUNC_FINISH = 1'b1;

  // Result error codes.
  typedef enum logic [1:0] {
    ERR_NONE        = 2'd0,
    ERR_ADD_DROPPED = 2'd1,
    ERR_IDLE_FINISH = 2'd2
  } err_t;

  // One queue entry as it sits in memory.
  typedef struct packed {
    logic [3:0] prio;
    logic [7:0] handler;
  } qentry_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_PUT,
    S_POP,
    S_HEAD_RD,
    S_HEAD_CHK
  } state_t;

endpackage

FILE: hw/rtl/preemptive_priority_task_dispatcher.sv
// Nested priority task dispatcher. An add item (func 0) inserts a handler
// id into a queue kept sorted by priority, lower value first, equal values
// in arrival order; a finish item (func 1) restores the priority saved when
// the running task was dispatched. After each item the queue head is started
// if it is strictly more urgent than the running priority, and exactly one
// result comes back per item. The queue lives in a circular memory: an add
// moves the entries behind the insert point up one place, one entry per
// cycle through the single read and write port. Saved priorities sit in a
// second memory used as a stack. One item is worked on at a time; the next
// one is taken while the previous result still waits at the output.
// base_priority is written through cfg_write_en / cfg_write_data; the user
// must write it only while the block is idle; the block itself does not
// enforce this. It sets the running priority when nothing is nested.
module preemptive_priority_task_dispatcher #(
  parameter int QUEUE_DEPTH = pptd_pkg::DEF_QUEUE_DEPTH,
  parameter int NEST_DEPTH  = pptd_pkg::DEF_NEST_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write_en,
  input  logic [3:0] cfg_write_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       func,
  input  logic [3:0] task_priority,
  input  logic [7:0] handler_id,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       dispatch,
  output logic [7:0] dispatch_handler,
  output logic [3:0] dispatch_priority,
  output logic [3:0] running_priority,
  output logic [1:0] error_code
);
  import pptd_pkg::*;

  localparam int QAW = $clog2(QUEUE_DEPTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int NAW = $clog2(NEST_DEPTH);
  localparam int NCW = $clog2(NEST_DEPTH + 1);
  localparam logic [QCW:0]   QD_EXT  = (QCW + 1)'(QUEUE_DEPTH);
  localparam logic [QCW-1:0] QD_FULL = QCW'(QUEUE_DEPTH);
  localparam logic [QAW-1:0] QD_LAST = QAW'(QUEUE_DEPTH - 1);
  localparam logic [NCW-1:0] ND_FULL = NCW'(NEST_DEPTH);

  state_t state, state_next;

  // Queue and nesting bookkeeping.
  logic [QAW-1:0] head;
  logic [QCW-1:0] count;
  logic [QCW-1:0] k;
  logic [NCW-1:0] nest;
  logic [3:0]     cur;

  // Item held during its work.
  qentry_t    item_entry;
  err_t       err;

  // Memory ports.
  logic           q_we;
  logic [QAW-1:0] q_waddr;
  logic [QAW-1:0] q_raddr;
  qentry_t        q_wdata;
  qentry_t        q_rdata;
  logic           s_we;
  logic [NAW-1:0] s_waddr;
  logic [NAW-1:0] s_raddr;
  logic [3:0]     s_rdata;

  logic add_drop;
  logic walk_shift;
  logic take;
  logic out_free;
  logic [QAW-1:0] head_inc;

  // Physical slot of the entry at logical place pos behind the head.
  function automatic logic [QAW-1:0] phys(input logic [QAW-1:0] hd,
                                          input logic [QCW-1:0] pos);
    logic [QCW:0] s;
    s = (QCW + 1)'(hd) + {1'b0, pos};
    if (s >= QD_EXT) begin
      s = s - QD_EXT;
    end
    return s[QAW-1:0];
  endfunction

  pptd_ram #(
    .WIDTH ($bits(qentry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  pptd_ram #(
    .WIDTH (4),
    .DEPTH (NEST_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (cur),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  // Conditions shared by control and datapath.
  assign add_drop   = (count == QD_FULL) || (nest == ND_FULL);
  assign walk_shift = q_rdata.prio > item_entry.prio;
  assign take       = (count != '0) && (nest != ND_FULL) && (q_rdata.prio < cur);
  assign out_free   = !out_valid || !out_stall;
  assign head_inc   = (head == QD_LAST) ? '0 : head + QAW'(1);
  assign in_stall   = (state != S_IDLE);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (func == FUNC_ADD) begin
            if (add_drop || count == '0) begin
              state_next = S_HEAD_RD;
            end else begin
              state_next = S_WALK;
            end
          end else if (nest == '0) begin
            state_next = S_HEAD_RD;
          end else begin
            state_next = S_POP;
          end
        end
      end
      S_WALK: begin
        if (!walk_shift) begin
          state_next = S_HEAD_RD;
        end else if (k == QCW'(1)) begin
          state_next = S_PUT;
        end
      end
      S_PUT:      state_next = S_HEAD_RD;
      S_POP:      state_next = S_HEAD_RD;
      S_HEAD_RD:  state_next = S_HEAD_CHK;
      S_HEAD_CHK: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:    state_next = S_IDLE;
    endcase
  end

  // Memory control per state.
  always_comb begin
    q_we    = 1'b0;
    q_waddr = head;
    q_wdata = item_entry;
    q_raddr = head;
    s_we    = 1'b0;
    s_waddr = nest[NAW-1:0];
    s_raddr = (nest != '0) ? NAW'(nest - 1'b1) : '0;
    case (state)
      S_IDLE: begin
        // Read the tail entry; an add into an empty queue writes the head slot.
        q_raddr = phys(head, (count != '0) ? count - 1'b1 : '0);
        q_wdata = '{prio: task_priority, handler: handler_id};
        q_we    = in_valid && (func == FUNC_ADD) && !add_drop && (count == '0);
      end
      S_WALK: begin
        // Move the entry up one place, or drop the new one in behind it.
        q_we    = 1'b1;
        q_waddr = phys(head, k);
        q_wdata = walk_shift ? q_rdata : item_entry;
        q_raddr = phys(head, (k >= QCW'(2)) ? k - QCW'(2) : '0);
      end
      S_PUT: begin
        q_we    = 1'b1;
        q_waddr = head;
      end
      S_HEAD_CHK: begin
        s_we = out_free && take;
      end
      default: begin
      end
    endcase
  end

  // Datapath and bookkeeping registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      nest      <= '0;
      cur       <= RESET_BASE_PRIORITY;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      // A new result replaces the old one as it leaves.
      if (state == S_HEAD_CHK && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_write_en) begin
        if (nest == '0) begin
          cur <= cfg_write_data;
        end
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            item_entry <= '{prio: task_priority, handler: handler_id};
            k          <= count;
            err        <= ERR_NONE;
            if (func == FUNC_ADD) begin
              if (add_drop) begin
                err <= ERR_ADD_DROPPED;
              end else if (count == '0) begin
                count <= count + 1'b1;
              end
            end else if (nest == '0) begin
              err <= ERR_IDLE_FINISH;
            end else begin
              nest <= nest - 1'b1;
            end
          end
        end
        S_WALK: begin
          if (walk_shift) begin
            k <= k - 1'b1;
          end else begin
            count <= count + 1'b1;
          end
        end
        S_PUT: begin
          count <= count + 1'b1;
        end
        S_POP: begin
          cur <= s_rdata;
        end
        S_HEAD_CHK: begin
          if (out_free) begin
            dispatch         <= take;
            error_code       <= err;
            dispatch_handler <= take ? q_rdata.handler : 8'd0;
            dispatch_priority <= take ? q_rdata.prio : 4'd0;
            running_priority <= take ? q_rdata.prio : cur;
            if (take) begin
              head  <= head_inc;
              count <= count - 1'b1;
              nest  <= nest + 1'b1;
              cur   <= q_rdata.prio;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/pptd_ram.sv
module pptd_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // One read port with registered data.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
